// File: hw/rtl/lcs_pkg.sv
package lcs_pkg;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [5:0]  MAX_RETRIES_RESET    = 6'd5;
    localparam logic [15:0] ONLINE_TIMEOUT_RESET = 16'd8000;
    localparam logic [19:0] BROKER_STALL_RESET   = 20'd30000;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int BACKOFF_BITS      = 21;

    localparam logic signed [7:0] RSSI_UNKNOWN = -8'sd100;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MAX_RETRIES    = 2'd0;
    localparam logic [1:0] REG_ONLINE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_BROKER_STALL   = 2'd2;

    // Operation codes.
    localparam logic [2:0] OP_TASK       = 3'd0;
    localparam logic [2:0] OP_START      = 3'd1;
    localparam logic [2:0] OP_CONNECT    = 3'd2;
    localparam logic [2:0] OP_DISCONNECT = 3'd3;
    localparam logic [2:0] OP_RESUME     = 3'd4;

    // Frame kinds.
    localparam logic [2:0] FK_UNKNOWN     = 3'd0;
    localparam logic [2:0] FK_DISCONNECT  = 3'd1;
    localparam logic [2:0] FK_BROKER      = 3'd2;
    localparam logic [2:0] FK_ONLINE_RSSI = 3'd3;
    localparam logic [2:0] FK_RSSI        = 3'd4;
    localparam logic [2:0] FK_OFF         = 3'd5;
    localparam logic [2:0] FK_ON          = 3'd6;
    localparam logic [2:0] FK_SETFREQ     = 3'd7;

    // Soft-start states.
    localparam logic [1:0] SS_IDLE  = 2'd0;
    localparam logic [1:0] SS_SWEEP = 2'd1;
    localparam logic [1:0] SS_DONE  = 2'd2;

    // LED settings.
    localparam logic [2:0] LED_NONE = 3'd0;
    localparam logic [2:0] LED_OFF  = 3'd1;
    localparam logic [2:0] LED_SLOW = 3'd2;
    localparam logic [2:0] LED_FAST = 3'd3;
    localparam logic [2:0] LED_ON   = 3'd4;

    // Command requests.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_RAMP  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_WIFI    = 3'd1,
        ST_BROKER  = 3'd2,
        ST_ONLINE  = 3'd3,
        ST_PASSIVE = 3'd4,
        ST_ACTIVE  = 3'd5
    } link_state_t;

    typedef struct packed {
        logic [2:0]        operation;
        logic [31:0]       now_ms;
        logic              module_ready;
        logic              frame_present;
        logic [2:0]        frame_kind;
        logic signed [7:0] rssi_value;
        logic [19:0]       freq_hz;
        logic              no_wifi_mode;
        logic [1:0]        soft_start_state;
        logic              disc_sent_ok;
    } item_t;

    typedef struct packed {
        logic [2:0]        conn_state;
        logic [5:0]        retry_count;
        logic signed [7:0] rssi;
        logic [2:0]        led_mode;
        logic              module_init_request;
        logic [1:0]        cmd_request;
        logic [19:0]       cmd_freq;
        logic              frame_accepted;
    } result_t;

    typedef struct packed {
        logic [5:0]  max_retries;
        logic [15:0] online_timeout_ms;
        logic [19:0] broker_stall_ms;
    } cfg_t;

    typedef struct packed {
        link_state_t       link_state;
        logic [5:0]        retries;
        logic signed [7:0] signal_dbm;
    } ctx_t;

    // Retry timeout as a function of the retry count.
    function automatic logic [BACKOFF_BITS-1:0] backoff_ms(input logic [5:0] n);
        logic [BACKOFF_BITS-1:0] t;
        begin
            if (n < 6'd3)
            begin
                t = 21'd5000;
            end
            else if (n < 6'd6)
            begin
                t = 21'd15000;
            end
            else if (n < 6'd10)
            begin
                t = 21'd30000;
            end
            else if (n < 6'd15)
            begin
                t = 21'd60000;
            end
            else if (n < 6'd25)
            begin
                t = 21'd120000;
            end
            else if (n < 6'd40)
            begin
                t = 21'd300000;
            end
            else
            begin
                t = 21'd1800000;
            end
            return t;
        end
    endfunction

endpackage

// File: hw/rtl/link_connection_supervisor.sv
// Link connection supervisor.
//
// Input channel: one transaction on item/item_valid/item_stall carries one
// timestamped operation (a periodic task with an optional pre-classified
// frame, or a control event). Output channel: every accepted transaction
// yields exactly one result transaction on result/result_valid/result_stall,
// carrying the link state, retry count, RSSI, LED setting and any request.
// The three configuration registers sit on the APB-style port at byte
// addresses 0, 4 and 8; they should only be written while the block is idle.
//
// An accepted transaction is held in the input register and moves on to the
// result register once the result side is free; result_valid then rises
// and the result can be taken. One transaction is accepted in every cycle
// while the receiver does not stall; the rate is set by the single state
// update per cycle between the input register and the result register.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more, after which item_stall rises.
// An asynchronous reset (rst_n low) returns the link to idle with no retries,
// zeroed timestamps, an RSSI of -100 dBm and the default register values.
module link_connection_supervisor #(
    parameter int TIME_BITS = lcs_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcs_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [lcs_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [lcs_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  lcs_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output lcs_pkg::result_t                  result
);
    import lcs_pkg::*;

    cfg_t                 cfg;

    // Input register: holds one transaction while the result side is stalled.
    logic                 item_valid_reg;
    item_t                item_reg;

    // Link state carried from one transaction to the next.
    ctx_t                 ctx_reg;
    ctx_t                 ctx_next;
    logic [TIME_BITS-1:0] attempt_ms_reg;
    logic [TIME_BITS-1:0] attempt_ms_next;
    logic [TIME_BITS-1:0] last_ms_reg;
    logic [TIME_BITS-1:0] last_ms_next;

    // Result register.
    logic                 result_valid_reg;
    result_t              result_reg;
    result_t              result_next;

    logic                 advance;
    logic                 accept;

    lcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcs_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .cfg             (cfg),
        .ctx             (ctx_reg),
        .attempt_ms      (attempt_ms_reg),
        .last_ms         (last_ms_reg),
        .item            (item_reg),
        .ctx_next        (ctx_next),
        .attempt_ms_next (attempt_ms_next),
        .last_ms_next    (last_ms_next),
        .result          (result_next)
    );

    // The held transaction moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg     <= 1'b0;
            result_valid_reg   <= 1'b0;
            ctx_reg.link_state <= ST_IDLE;
            ctx_reg.retries    <= '0;
            ctx_reg.signal_dbm <= RSSI_UNKNOWN;
            attempt_ms_reg     <= '0;
            last_ms_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
                ctx_reg          <= ctx_next;
                attempt_ms_reg   <= attempt_ms_next;
                last_ms_reg      <= last_ms_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: hw/rtl/lcs_regs.sv
module lcs_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lcs_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [lcs_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [lcs_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    output lcs_pkg::cfg_t                        cfg
);
    import lcs_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_retries       <= MAX_RETRIES_RESET;
            cfg_reg.online_timeout_ms <= ONLINE_TIMEOUT_RESET;
            cfg_reg.broker_stall_ms   <= BROKER_STALL_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_MAX_RETRIES:    cfg_reg.max_retries       <= pwdata[5:0];
                REG_ONLINE_TIMEOUT: cfg_reg.online_timeout_ms <= pwdata[15:0];
                REG_BROKER_STALL:   cfg_reg.broker_stall_ms   <= pwdata[19:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MAX_RETRIES:    prdata = CFG_DATA_BITS'(cfg_reg.max_retries);
            REG_ONLINE_TIMEOUT: prdata = CFG_DATA_BITS'(cfg_reg.online_timeout_ms);
            REG_BROKER_STALL:   prdata = CFG_DATA_BITS'(cfg_reg.broker_stall_ms);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/lcs_step.sv
module lcs_step #(
    parameter int TIME_BITS = lcs_pkg::TIME_BITS_DEFAULT
) (
    input  lcs_pkg::cfg_t        cfg,
    input  lcs_pkg::ctx_t        ctx,
    input  logic [TIME_BITS-1:0] attempt_ms,
    input  logic [TIME_BITS-1:0] last_ms,
    input  lcs_pkg::item_t       item,
    output lcs_pkg::ctx_t        ctx_next,
    output logic [TIME_BITS-1:0] attempt_ms_next,
    output logic [TIME_BITS-1:0] last_ms_next,
    output lcs_pkg::result_t     result
);
    import lcs_pkg::*;

    localparam int CMP_BITS = (TIME_BITS > BACKOFF_BITS) ? TIME_BITS : BACKOFF_BITS;

    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic [2:0]           kind;
    logic                 rssi_ok;
    logic                 have;
    logic                 linked;
    logic                 cmd_open;
    link_state_t          ls;
    link_state_t          cs;
    logic [5:0]           rt;
    logic signed [7:0]    sg;
    logic [TIME_BITS-1:0] at;
    logic [TIME_BITS-1:0] lf;
    logic [TIME_BITS-1:0] since_at;
    logic [TIME_BITS-1:0] since_lf_b;
    logic [TIME_BITS-1:0] since_lf_o;
    logic [2:0]           led;
    logic                 init_req;
    logic [1:0]           cmd;
    logic [19:0]          cf;
    logic                 acc;

    assign now_wide = 64'(item.now_ms);
    assign now_t    = now_wide[TIME_BITS-1:0];
    // An rssi value must lie between -127 and 0 inclusive.
    assign rssi_ok  = (item.rssi_value == 8'sd0) ||
                      (item.rssi_value[7] && (item.rssi_value[6:0] != 7'd0));
    assign cmd_open = !item.no_wifi_mode;

    always_comb
    begin
        ls         = ctx.link_state;
        rt         = ctx.retries;
        sg         = ctx.signal_dbm;
        at         = attempt_ms;
        lf         = last_ms;
        led        = LED_NONE;
        init_req   = 1'b0;
        cmd        = CMD_NONE;
        cf         = '0;
        acc        = 1'b0;
        have       = item.frame_present;
        cs         = ls;
        since_at   = '0;
        since_lf_b = '0;
        since_lf_o = '0;
        linked     = 1'b0;

        kind = item.frame_kind;
        if (((kind == FK_ONLINE_RSSI) || (kind == FK_RSSI)) && !rssi_ok)
        begin
            kind = FK_UNKNOWN;
        end

        case (item.operation)
            OP_TASK:
            begin
                if (item.module_ready)
                begin
                    // Passive offline: a link frame brings the connection back.
                    if ((ls == ST_PASSIVE) && have)
                    begin
                        have = 1'b0;
                        if (kind inside {FK_BROKER, FK_ONLINE_RSSI, FK_RSSI})
                        begin
                            ls  = ST_WIFI;
                            rt  = '0;
                            at  = now_t;
                            lf  = now_t;
                            led = LED_SLOW;
                            acc = 1'b1;
                        end
                    end

                    if ((ls == ST_WIFI) || (ls == ST_BROKER))
                    begin
                        since_at = now_t - at;
                        if (CMP_BITS'(since_at) >= CMP_BITS'(backoff_ms(rt)))
                        begin
                            rt = rt + 6'd1;
                            if (rt >= cfg.max_retries)
                            begin
                                ls  = ST_PASSIVE;
                                rt  = '0;
                                led = LED_OFF;
                            end
                            else
                            begin
                                at  = now_t;
                                lf  = now_t;
                                led = LED_SLOW;
                            end
                        end
                        since_lf_b = now_t - lf;
                        if ((ls == ST_BROKER) &&
                            (CMP_BITS'(since_lf_b) >= CMP_BITS'(cfg.broker_stall_ms)))
                        begin
                            ls  = ST_WIFI;
                            rt  = '0;
                            at  = now_t;
                            lf  = now_t;
                            led = LED_SLOW;
                        end
                    end

                    since_lf_o = now_t - lf;
                    if ((ls == ST_ONLINE) &&
                        (CMP_BITS'(since_lf_o) >= CMP_BITS'(cfg.online_timeout_ms)))
                    begin
                        ls  = ST_WIFI;
                        rt  = '0;
                        at  = now_t;
                        lf  = now_t;
                        led = LED_SLOW;
                        sg  = RSSI_UNKNOWN;
                    end

                    if (have && (ls != ST_PASSIVE) && (ls != ST_ACTIVE))
                    begin
                        cs  = ls;
                        acc = (kind != FK_UNKNOWN);
                        case (kind)
                            FK_DISCONNECT:
                            begin
                                ls  = ST_WIFI;
                                rt  = '0;
                                at  = now_t;
                                sg  = RSSI_UNKNOWN;
                                led = LED_SLOW;
                            end
                            FK_BROKER:
                            begin
                                if (cs == ST_WIFI)
                                begin
                                    ls  = ST_BROKER;
                                    at  = now_t;
                                    led = LED_FAST;
                                end
                            end
                            FK_ONLINE_RSSI:
                            begin
                                sg = item.rssi_value;
                                if (cs != ST_ONLINE)
                                begin
                                    ls  = ST_ONLINE;
                                    rt  = '0;
                                    led = LED_ON;
                                end
                            end
                            FK_RSSI:
                            begin
                                sg = item.rssi_value;
                            end
                            FK_OFF:
                            begin
                                if (cmd_open && (item.soft_start_state inside {SS_SWEEP, SS_DONE}))
                                begin
                                    cmd = CMD_STOP;
                                end
                            end
                            FK_ON:
                            begin
                                if (cmd_open && (item.soft_start_state == SS_IDLE))
                                begin
                                    cmd = CMD_START;
                                end
                            end
                            FK_SETFREQ:
                            begin
                                if (cmd_open && (item.soft_start_state == SS_DONE))
                                begin
                                    cmd = CMD_RAMP;
                                    cf  = item.freq_hz;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (acc)
                        begin
                            lf = now_t;
                        end
                    end
                end
            end
            OP_START:
            begin
                ls       = ST_WIFI;
                rt       = '0;
                at       = now_t;
                lf       = now_t;
                led      = LED_SLOW;
                init_req = 1'b1;
            end
            OP_CONNECT:
            begin
                if (ls == ST_ACTIVE)
                begin
                    ls       = ST_WIFI;
                    rt       = '0;
                    at       = now_t;
                    lf       = now_t;
                    led      = LED_SLOW;
                    init_req = 1'b1;
                end
            end
            OP_DISCONNECT:
            begin
                linked = ls inside {ST_WIFI, ST_BROKER, ST_ONLINE};
                if (!linked || item.disc_sent_ok)
                begin
                    ls  = ST_ACTIVE;
                    rt  = '0;
                    sg  = RSSI_UNKNOWN;
                    led = LED_OFF;
                end
            end
            OP_RESUME:
            begin
                if (ls == ST_PASSIVE)
                begin
                    ls  = ST_WIFI;
                    rt  = '0;
                    at  = now_t;
                    lf  = now_t;
                    led = LED_SLOW;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ctx_next.link_state = ls;
    assign ctx_next.retries    = rt;
    assign ctx_next.signal_dbm = sg;
    assign attempt_ms_next     = at;
    assign last_ms_next        = lf;

    assign result.conn_state          = ls;
    assign result.retry_count         = rt;
    assign result.rssi                = sg;
    assign result.led_mode            = led;
    assign result.module_init_request = init_req;
    assign result.cmd_request         = cmd;
    assign result.cmd_freq            = cf;
    assign result.frame_accepted      = acc;

endmodule

// File: hw/rtl/lcs_checker.sv
module lcs_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  logic             result_valid,
    input  logic             result_stall,
    input  lcs_pkg::result_t result
);
    import lcs_pkg::*;

    // A stalled result stays on the port unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or vanished");

    // Every accepted transaction shows a result after the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> ##1 result_valid)
        else $error("accepted transaction produced no result in time");

    // A frequency only travels with a ramp request.
    a_freq_gate: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.cmd_request != CMD_RAMP) |-> result.cmd_freq == '0)
        else $error("frequency reported without ramp request");

    // Both offline states clear the retry count.
    a_offline_retries: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.conn_state == ST_PASSIVE) ||
                         (result.conn_state == ST_ACTIVE)) |-> result.retry_count == '0)
        else $error("retry count not cleared while offline");

    // Module initialisation always starts a fresh wifi attempt.
    a_init_wifi: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.module_init_request |->
            (result.conn_state == ST_WIFI) && (result.led_mode == LED_SLOW))
        else $error("initialisation request outside a fresh wifi attempt");

endmodule

bind link_connection_supervisor lcs_checker u_lcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
